### design/scfh_pkg.sv
// ----------------------------------------------------------------------------
// scfh_pkg: shared types and constants for the scoped FNV-1a ID hasher
// Request and response item layouts, request and status codes, hash constants.
// ----------------------------------------------------------------------------
package scfh_pkg;

  // FNV-1a 32-bit constants
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  // Request kinds
  typedef enum logic [2:0] {
    REQ_BYTE        = 3'd0,
    REQ_FINISH      = 3'd1,
    REQ_FINISH_INT  = 3'd2,
    REQ_SCOPED      = 3'd3,
    REQ_SCOPED_INT  = 3'd4,
    REQ_PUSH_STR    = 3'd5,
    REQ_PUSH_INT    = 3'd6,
    REQ_POP         = 3'd7
  } req_kind_t;

  // Response status codes
  typedef enum logic [2:0] {
    ST_ID          = 3'd0,
    ST_PUSH_DONE   = 3'd1,
    ST_PUSH_FULL   = 3'd2,
    ST_POP_DONE    = 3'd3,
    ST_POP_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [7:0]         data_byte;
    logic signed [31:0] number;
  } req_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic [5:0]  stack_level;
    status_t     status;
  } rsp_t;

endpackage

### design/scfh_stack_ram.sv
// ----------------------------------------------------------------------------
// scfh_stack_ram: scope stack storage
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module scfh_stack_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### design/scoped_fnv1a_id_hasher.sv
// ----------------------------------------------------------------------------
// scoped_fnv1a_id_hasher: 32-bit FNV-1a ID hasher with a scope stack
// Folds string bytes into a running hash, emits IDs on finish items and keeps
// a stack of parent scope hashes in a synchronous RAM.
// ----------------------------------------------------------------------------
// Byte items: taken every cycle, non-zero bytes folded into the hash, no result.
// Push, pop and unscoped finish: S_EMIT registers the result into rsp once the
//   output is free, and the next item is taken after the return to S_IDLE.
// Scoped finish: S_WALK folds the N stacked entries from the bottom up, then
//   S_EMIT registers the result; the RAM read port delivers one entry per cycle.
// Reset: running hash to the offset basis, stack empty; RAM contents are kept.
module scoped_fnv1a_id_hasher #(
  parameter int STACK_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  scfh_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output scfh_pkg::rsp_t rsp
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

  function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] x;
    x = h ^ v;
    return x * scfh_pkg::HASH_PRIME;
  endfunction

  state_t            state;
  logic [31:0]       running_hash;
  logic [CW-1:0]     count;
  logic [CW-1:0]     walk_idx;
  logic [CW-1:0]     walk_nxt;
  logic [31:0]       res_id;
  scfh_pkg::status_t res_status;

  logic              accept;
  logic              out_free;
  logic              full;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       wr_data;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       rd_data;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign full      = (count == CW'(STACK_DEPTH));
  assign walk_nxt  = walk_idx + 1'b1;

  // Push writes the new top entry
  always_comb begin
    wr_en   = accept && !full &&
              (req.req_type == scfh_pkg::REQ_PUSH_STR ||
               req.req_type == scfh_pkg::REQ_PUSH_INT);
    wr_addr = count[AW-1:0];
    wr_data = (req.req_type == scfh_pkg::REQ_PUSH_STR) ? running_hash :
              fold_word(scfh_pkg::HASH_BASIS, req.number);
  end

  // Read bottom entry on accept, then the next one each walk cycle
  assign rd_addr = (state == S_WALK) ? walk_nxt[AW-1:0] : '0;

  scfh_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (32),
    .AW    (AW)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, hash state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= scfh_pkg::HASH_BASIS;
      count        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads this cycle
      if (rsp_valid && rsp_ready && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            walk_idx <= '0;
            case (req.req_type)
              scfh_pkg::REQ_BYTE: begin
                if (req.data_byte != 8'd0) begin
                  running_hash <= fold_word(running_hash, {24'd0, req.data_byte});
                end
              end
              scfh_pkg::REQ_FINISH, scfh_pkg::REQ_SCOPED: begin
                res_id       <= running_hash;
                res_status   <= scfh_pkg::ST_ID;
                running_hash <= scfh_pkg::HASH_BASIS;
                state        <= (req.req_type == scfh_pkg::REQ_SCOPED && count != '0) ?
                                S_WALK : S_EMIT;
              end
              scfh_pkg::REQ_FINISH_INT, scfh_pkg::REQ_SCOPED_INT: begin
                res_id       <= fold_word(running_hash, req.number);
                res_status   <= scfh_pkg::ST_ID;
                running_hash <= scfh_pkg::HASH_BASIS;
                state        <= (req.req_type == scfh_pkg::REQ_SCOPED_INT && count != '0) ?
                                S_WALK : S_EMIT;
              end
              scfh_pkg::REQ_PUSH_STR, scfh_pkg::REQ_PUSH_INT: begin
                res_id <= '0;
                state  <= S_EMIT;
                if (full) begin
                  res_status <= scfh_pkg::ST_PUSH_FULL;
                end else begin
                  res_status <= scfh_pkg::ST_PUSH_DONE;
                  count      <= count + 1'b1;
                  if (req.req_type == scfh_pkg::REQ_PUSH_STR) begin
                    running_hash <= scfh_pkg::HASH_BASIS;
                  end
                end
              end
              default: begin
                // pop
                res_id <= '0;
                state  <= S_EMIT;
                if (count == '0) begin
                  res_status <= scfh_pkg::ST_POP_EMPTY;
                end else begin
                  res_status <= scfh_pkg::ST_POP_DONE;
                  count      <= count - 1'b1;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          // Fold the entry whose read returned this cycle
          res_id   <= fold_word(res_id, rd_data);
          walk_idx <= walk_nxt;
          if (walk_nxt == count) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp.result_id   <= res_id;
            rsp.stack_level <= 6'(count);
            rsp.status      <= res_status;
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> walk_idx < count)
    else $error("scope walk past the stack top");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("scope count above stack depth");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !wr_en)
    else $error("stack write while busy");

endmodule
